@@ design/motor_speed_command_framer_top_defines.svh @@
// Assertion macros for the motor speed command framer checker.
// Included by the checker file only; no dependencies.
`ifndef MOTOR_SPEED_COMMAND_FRAMER_TOP_DEFINES_SVH
`define MOTOR_SPEED_COMMAND_FRAMER_TOP_DEFINES_SVH

// Concurrent check, masked while reset is asserted.
`define MSF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define MSF_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/msf_pkg.sv @@
// Shared types, constants and divider step function for the motor speed framer.
// No dependencies.
package msf_pkg;

  localparam int SPEED_W    = 16;
  localparam int REG_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int FRAME_LEN  = 9;
  localparam int IDX_W      = $clog2(FRAME_LEN);
  localparam int QDEPTH     = 2;
  localparam int QAW        = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int DIV_STEPS  = SPEED_W / 2;
  localparam int DCNT_W     = $clog2(DIV_STEPS);

  localparam logic [REG_W-1:0] HEADER_BYTE = 8'h23;
  localparam logic [REG_W-1:0] PAD_BYTE    = 8'h00;

  localparam logic [CFG_IDX_W-1:0] REG_DIVIDE_FACTOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_LIMIT = 2'd1;

  localparam logic [IDX_W-1:0] BYTE_HDR0     = 4'd0;
  localparam logic [IDX_W-1:0] BYTE_HDR1     = 4'd1;
  localparam logic [IDX_W-1:0] BYTE_HDR2     = 4'd2;
  localparam logic [IDX_W-1:0] BYTE_LEFT_LO  = 4'd3;
  localparam logic [IDX_W-1:0] BYTE_LEFT_HI  = 4'd4;
  localparam logic [IDX_W-1:0] BYTE_RIGHT_LO = 4'd5;
  localparam logic [IDX_W-1:0] BYTE_RIGHT_HI = 4'd6;
  localparam logic [IDX_W-1:0] BYTE_PAD0     = 4'd7;
  localparam logic [IDX_W-1:0] BYTE_LAST     = 4'd8;

  typedef struct packed {
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
  } in_item_t;

  typedef struct packed {
    logic [REG_W-1:0] frame_byte;
    logic             frame_end;
  } out_item_t;

  typedef struct packed {
    logic [REG_W-1:0] divide_factor;
    logic [REG_W-1:0] magnitude_limit;
  } cfg_t;

  // Sign and magnitude of both speeds, as split by the front end.
  typedef struct packed {
    logic               left_neg;
    logic [SPEED_W-1:0] left_mag;
    logic               right_neg;
    logic [SPEED_W-1:0] right_mag;
  } cls_item_t;

  typedef struct packed {
    logic [REG_W-1:0]   rem;
    logic [SPEED_W-1:0] quo;
  } div_state_t;

  // Two restoring division steps: shift one dividend bit into the remainder each.
  function automatic div_state_t div_step2(div_state_t s, logic [REG_W-1:0] d);
    logic [REG_W:0] sh;
    logic           ge;
    div_state_t     r;
    r = s;
    for (int k = 0; k < 2; k++) begin
      sh    = {r.rem, r.quo[SPEED_W-1]};
      ge    = (sh >= {1'b0, d});
      r.rem = ge ? REG_W'(sh - {1'b0, d}) : sh[REG_W-1:0];
      r.quo = {r.quo[SPEED_W-2:0], ge};
    end
    return r;
  endfunction

endpackage

@@ design/msf_front.sv @@
// Front end: input register that splits each speed into sign and magnitude.
// Depends on msf_pkg.
module msf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  msf_pkg::in_item_t  in_data,
  output logic               push,
  output msf_pkg::cls_item_t push_data,
  input  logic               q_full
);

  logic               fr_valid_r, fr_valid_nxt;
  msf_pkg::cls_item_t fr_data_r;
  logic               accept;

  assign in_stall  = fr_valid_r && q_full;
  assign accept    = in_valid && !in_stall;
  assign push      = fr_valid_r && !q_full;
  assign push_data = fr_data_r;

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (accept) begin
      fr_valid_nxt = 1'b1;
    end else if (push) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_data_r.left_neg  <= in_data.left_speed[msf_pkg::SPEED_W-1];
      fr_data_r.left_mag  <= in_data.left_speed[msf_pkg::SPEED_W-1]
                             ? msf_pkg::SPEED_W'(~in_data.left_speed + 1'b1)
                             : in_data.left_speed;
      fr_data_r.right_neg <= in_data.right_speed[msf_pkg::SPEED_W-1];
      fr_data_r.right_mag <= in_data.right_speed[msf_pkg::SPEED_W-1]
                             ? msf_pkg::SPEED_W'(~in_data.right_speed + 1'b1)
                             : in_data.right_speed;
    end
  end

endmodule

@@ design/msf_queue.sv @@
// Short FIFO between the front end and the divide/serialize back end.
// Depends on msf_pkg.
module msf_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  msf_pkg::cls_item_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output msf_pkg::cls_item_t q_data
);

  msf_pkg::cls_item_t              mem_r [msf_pkg::QDEPTH];
  logic [msf_pkg::QAW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [msf_pkg::QAW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [msf_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;

  assign full    = (cnt_r == msf_pkg::QCNT_W'(msf_pkg::QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == msf_pkg::QAW'(msf_pkg::QDEPTH - 1)) ? '0
                   : msf_pkg::QAW'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == msf_pkg::QAW'(msf_pkg::QDEPTH - 1)) ? '0
                   : msf_pkg::QAW'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = msf_pkg::QCNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = msf_pkg::QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ design/msf_back.sv @@
// Back end: iterative divider for both speeds, clamp, and 9-byte frame serializer.
// Depends on msf_pkg.
module msf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  msf_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  msf_pkg::cls_item_t q_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output msf_pkg::out_item_t out_data
);

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } div_fsm_t;

  div_fsm_t                     st_r, st_nxt;
  logic [msf_pkg::DCNT_W-1:0]   cnt_r, cnt_nxt;
  msf_pkg::div_state_t          ldiv_r, rdiv_r;
  logic                         lneg_r, rneg_r;

  logic                         ser_busy_r, ser_busy_nxt;
  logic [msf_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [msf_pkg::SPEED_W-1:0]  left_r, right_r;

  logic [msf_pkg::REG_W-1:0]    divisor;
  logic                         out_take, ser_free, xfer;
  logic [msf_pkg::SPEED_W-1:0]  lim_ext, lclamp, rclamp, lres, rres;

  // A zero factor divides by one.
  assign divisor  = (cfg.divide_factor == '0) ? msf_pkg::REG_W'(1) : cfg.divide_factor;

  assign out_take = ser_busy_r && !out_stall;
  assign ser_free = !ser_busy_r || (out_take && idx_r == msf_pkg::BYTE_LAST);
  assign xfer     = (st_r == DIV_DONE) && ser_free;
  assign pop      = q_valid && ((st_r == DIV_IDLE) || xfer);

  // Clamp the magnitude, then restore the sign.
  assign lim_ext = msf_pkg::SPEED_W'(cfg.magnitude_limit);
  assign lclamp  = (ldiv_r.quo > lim_ext) ? lim_ext : ldiv_r.quo;
  assign rclamp  = (rdiv_r.quo > lim_ext) ? lim_ext : rdiv_r.quo;
  assign lres    = lneg_r ? msf_pkg::SPEED_W'(~lclamp + 1'b1) : lclamp;
  assign rres    = rneg_r ? msf_pkg::SPEED_W'(~rclamp + 1'b1) : rclamp;

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    case (st_r)
      DIV_IDLE: begin
        if (pop) begin
          st_nxt  = DIV_RUN;
          cnt_nxt = '0;
        end
      end
      DIV_RUN: begin
        cnt_nxt = msf_pkg::DCNT_W'(cnt_r + 1'b1);
        if (cnt_r == msf_pkg::DCNT_W'(msf_pkg::DIV_STEPS - 1)) begin
          st_nxt = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (pop) begin
          st_nxt  = DIV_RUN;
          cnt_nxt = '0;
        end else if (xfer) begin
          st_nxt = DIV_IDLE;
        end
      end
      default: begin
        st_nxt = DIV_IDLE;
      end
    endcase
  end

  always_comb begin
    ser_busy_nxt = ser_busy_r;
    idx_nxt      = idx_r;
    if (xfer) begin
      ser_busy_nxt = 1'b1;
      idx_nxt      = '0;
    end else if (out_take) begin
      if (idx_r == msf_pkg::BYTE_LAST) begin
        ser_busy_nxt = 1'b0;
      end else begin
        idx_nxt = msf_pkg::IDX_W'(idx_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= DIV_IDLE;
      cnt_r      <= '0;
      ser_busy_r <= 1'b0;
      idx_r      <= '0;
    end else begin
      st_r       <= st_nxt;
      cnt_r      <= cnt_nxt;
      ser_busy_r <= ser_busy_nxt;
      idx_r      <= idx_nxt;
    end
  end

  // Divider datapath: load magnitudes on pop, two quotient bits per cycle.
  always_ff @(posedge clk) begin
    if (pop) begin
      lneg_r     <= q_data.left_neg;
      rneg_r     <= q_data.right_neg;
      ldiv_r.rem <= '0;
      ldiv_r.quo <= q_data.left_mag;
      rdiv_r.rem <= '0;
      rdiv_r.quo <= q_data.right_mag;
    end else if (st_r == DIV_RUN) begin
      ldiv_r <= msf_pkg::div_step2(ldiv_r, divisor);
      rdiv_r <= msf_pkg::div_step2(rdiv_r, divisor);
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      left_r  <= lres;
      right_r <= rres;
    end
  end

  assign out_valid = ser_busy_r;

  always_comb begin
    out_data.frame_end = (idx_r == msf_pkg::BYTE_LAST);
    case (idx_r)
      msf_pkg::BYTE_HDR0,
      msf_pkg::BYTE_HDR1,
      msf_pkg::BYTE_HDR2:     out_data.frame_byte = msf_pkg::HEADER_BYTE;
      msf_pkg::BYTE_LEFT_LO:  out_data.frame_byte = left_r[7:0];
      msf_pkg::BYTE_LEFT_HI:  out_data.frame_byte = left_r[15:8];
      msf_pkg::BYTE_RIGHT_LO: out_data.frame_byte = right_r[7:0];
      msf_pkg::BYTE_RIGHT_HI: out_data.frame_byte = right_r[15:8];
      msf_pkg::BYTE_PAD0,
      msf_pkg::BYTE_LAST:     out_data.frame_byte = msf_pkg::PAD_BYTE;
      default:                out_data.frame_byte = msf_pkg::PAD_BYTE;
    endcase
  end

endmodule

@@ design/motor_speed_command_framer_top.sv @@
// An accepted speed pair passes the front register and the queue, is divided and
// clamped, and goes out as a 9-byte frame; the divider (two quotient bits per cycle)
// works on the next speed pair while the serializer sends the current frame.
// Reset (synchronous, rst_n low) empties the queue and serializer, factor 1, limit 0.
// Top level of the motor speed command framer; depends on msf_pkg, msf_front,
// msf_queue and msf_back.
module motor_speed_command_framer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  msf_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output msf_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [msf_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [msf_pkg::REG_W-1:0]       cfg_data
);

  msf_pkg::cfg_t      cfg_r;
  logic               push, full, pop, q_valid;
  msf_pkg::cls_item_t push_data, q_data;

  // Writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.divide_factor   <= msf_pkg::REG_W'(1);
      cfg_r.magnitude_limit <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        msf_pkg::REG_DIVIDE_FACTOR:   cfg_r.divide_factor   <= cfg_data;
        msf_pkg::REG_MAGNITUDE_LIMIT: cfg_r.magnitude_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  msf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (full)
  );

  msf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  msf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ design/msf_checker.sv @@
// Port-level checks on frame output for the motor speed command framer.
// Depends on msf_pkg and motor_speed_command_framer_top_defines.svh.
`include "motor_speed_command_framer_top_defines.svh"

module msf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input msf_pkg::out_item_t out_data
);

  `MSF_ASSERT_NR(a_idle_after_reset, clk, !rst_n |=> !out_valid, "output valid right after reset")

  `MSF_ASSERT(a_hold_stalled, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled beat changed")

  `MSF_ASSERT(a_last_is_pad, clk, rst_n, out_valid && out_data.frame_end |-> out_data.frame_byte == msf_pkg::PAD_BYTE, "frame end byte not zero")

  `MSF_ASSERT(a_header_follows_end, clk, rst_n, out_valid && !out_stall && out_data.frame_end |=> !out_valid || out_data.frame_byte == msf_pkg::HEADER_BYTE, "next frame does not open with header")

endmodule

bind motor_speed_command_framer_top msf_checker u_msf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
